/* hdl/integer_matrix_multiply_unit_defines.svh */
// Shared assertion macros for the matrix multiply unit.
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/imm_pkg.sv */
package imm_pkg;

	// fixed field widths
	localparam int DIM_W   = 3;
	localparam int REG_W   = 4;
	localparam int IDX_W   = 2;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 35;
	localparam int MULT_W  = 2 * ELEM_W;
	localparam int CELL_W  = 6;

	// default largest matrix dimension
	localparam int MAX_DIM_DEF = 8;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [IDX_W-1:0] REG_INNER  = 2'd1;
	localparam logic [IDX_W-1:0] REG_COLS_B = 2'd2;

	localparam logic [REG_W-1:0] DIM_RESET = 4'd8;

	// sequencer states
	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	// one multiply-accumulate step travelling down the pipeline
	typedef struct packed {
		logic             valid;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic             first;
		logic             last_k;
		logic             last;
	} mac_tag_t;

	// register value to last valid index: 0 acts as 1, above max acts as max
	function automatic logic [DIM_W-1:0] dim_lim(input logic [REG_W-1:0] v, input int max_dim);
		logic [REG_W-1:0] lim;
		if (v == '0) begin
			lim = '0;
		end else if (int'(v) > max_dim) begin
			lim = REG_W'(max_dim - 1);
		end else begin
			lim = v - 1'b1;
		end
		return lim[DIM_W-1:0];
	endfunction

	// row-major store location
	function automatic logic [CELL_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
		input logic [DIM_W-1:0] c, input int max_dim);
		logic [CELL_W-1:0] t;
		t = CELL_W'(r) * CELL_W'(max_dim) + CELL_W'(c);
		return t;
	endfunction

endpackage

/* hdl/imm_ram.sv */
module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/imm_ctrl.sv */
module imm_ctrl #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
	parameter int AW = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [imm_pkg::IDX_W-1:0] cfg_index,
	input  logic [imm_pkg::REG_W-1:0] cfg_data,
	input  logic                     element_valid,
	output logic                     element_ready,
	input  logic                     adv,
	input  logic                     calc_done,
	output logic                     a_wr_en,
	output logic                     b_wr_en,
	output logic [AW-1:0]            wr_addr,
	output logic [AW-1:0]            a_rd_addr,
	output logic [AW-1:0]            b_rd_addr,
	output imm_pkg::mac_tag_t        issue
);

	imm_pkg::state_t state_q;
	logic [imm_pkg::REG_W-1:0] rows_a_q, inner_q, cols_b_q;
	logic [imm_pkg::DIM_W-1:0] rows_lim, inner_lim, cols_lim;
	logic [imm_pkg::DIM_W-1:0] lr_q, lc_q, ir_q, ic_q, ik_q;
	logic phase_b_q, issued_q;
	logic accept, cfg_hit;
	logic lc_end, lr_end, ik_end, ic_end, ir_end, issue_go;

	assign rows_lim  = imm_pkg::dim_lim(rows_a_q, MAX_DIM);
	assign inner_lim = imm_pkg::dim_lim(inner_q, MAX_DIM);
	assign cols_lim  = imm_pkg::dim_lim(cols_b_q, MAX_DIM);

	assign element_ready = (state_q == imm_pkg::ST_LOAD);
	assign accept = element_valid && element_ready;

	// config decode
	always_comb begin
		unique case (cfg_index)
			imm_pkg::REG_ROWS_A, imm_pkg::REG_INNER, imm_pkg::REG_COLS_B: cfg_hit = cfg_write_en;
			default: cfg_hit = 1'b0;
		endcase
	end

	// load position: A is rows x inner, B is inner x cols
	assign lc_end = phase_b_q ? (lc_q == cols_lim) : (lc_q == inner_lim);
	assign lr_end = phase_b_q ? (lr_q == inner_lim) : (lr_q == rows_lim);

	assign a_wr_en = accept && !phase_b_q;
	assign b_wr_en = accept && phase_b_q;
	assign wr_addr = AW'(imm_pkg::cell_addr(lr_q, lc_q, MAX_DIM));

	// compute issue
	assign ik_end = (ik_q == inner_lim);
	assign ic_end = (ic_q == cols_lim);
	assign ir_end = (ir_q == rows_lim);
	assign issue_go = (state_q == imm_pkg::ST_CALC) && !issued_q;

	assign a_rd_addr = AW'(imm_pkg::cell_addr(ir_q, ik_q, MAX_DIM));
	assign b_rd_addr = AW'(imm_pkg::cell_addr(ik_q, ic_q, MAX_DIM));

	always_comb begin
		issue.valid  = issue_go;
		issue.row    = ir_q;
		issue.col    = ic_q;
		issue.first  = (ik_q == '0);
		issue.last_k = ik_end;
		issue.last   = ik_end && ic_end && ir_end;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= imm_pkg::DIM_RESET;
			inner_q  <= imm_pkg::DIM_RESET;
			cols_b_q <= imm_pkg::DIM_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				imm_pkg::REG_ROWS_A: rows_a_q <= cfg_data;
				imm_pkg::REG_INNER:  inner_q  <= cfg_data;
				imm_pkg::REG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= imm_pkg::ST_LOAD;
			lr_q      <= '0;
			lc_q      <= '0;
			phase_b_q <= 1'b0;
			ir_q      <= '0;
			ic_q      <= '0;
			ik_q      <= '0;
			issued_q  <= 1'b0;
		end else begin
			unique case (state_q)
				imm_pkg::ST_LOAD: begin
					if (cfg_hit) begin
						lr_q      <= '0;
						lc_q      <= '0;
						phase_b_q <= 1'b0;
					end else if (accept) begin
						if (!lc_end) begin
							lc_q <= lc_q + 1'b1;
						end else begin
							lc_q <= '0;
							if (!lr_end) begin
								lr_q <= lr_q + 1'b1;
							end else begin
								lr_q      <= '0;
								phase_b_q <= !phase_b_q;
								if (phase_b_q) begin
									state_q  <= imm_pkg::ST_CALC;
									ir_q     <= '0;
									ic_q     <= '0;
									ik_q     <= '0;
									issued_q <= 1'b0;
								end
							end
						end
					end
				end
				imm_pkg::ST_CALC: begin
					if (issue_go && adv) begin
						if (!ik_end) begin
							ik_q <= ik_q + 1'b1;
						end else begin
							ik_q <= '0;
							if (!ic_end) begin
								ic_q <= ic_q + 1'b1;
							end else begin
								ic_q <= '0;
								if (!ir_end) begin
									ir_q <= ir_q + 1'b1;
								end else begin
									issued_q <= 1'b1;
								end
							end
						end
					end
					if (calc_done) begin
						state_q <= imm_pkg::ST_LOAD;
					end
				end
				default: state_q <= imm_pkg::ST_LOAD;
			endcase
		end
	end

endmodule

/* hdl/imm_mac.sv */
module imm_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  imm_pkg::mac_tag_t                 issue,
	input  logic [imm_pkg::ELEM_W-1:0]        a_data,
	input  logic [imm_pkg::ELEM_W-1:0]        b_data,
	output logic                              adv,
	output logic                              calc_done,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [imm_pkg::DIM_W-1:0]         row_index,
	output logic [imm_pkg::DIM_W-1:0]         col_index,
	output logic signed [imm_pkg::PROD_W-1:0] product_value,
	output logic                              last_result
);

	imm_pkg::mac_tag_t tag_s1, tag_s2;
	logic signed [imm_pkg::MULT_W-1:0] prod_s2;
	logic signed [imm_pkg::PROD_W-1:0] acc_q, sum;
	logic result_valid_q, step;

	// whole pipeline moves unless a result is stuck at the output
	assign adv  = !result_valid_q || result_ready;
	assign step = adv && tag_s2.valid;
	assign calc_done = step && tag_s2.last;
	assign result_valid = result_valid_q;

	assign sum = (tag_s2.first ? '0 : acc_q) + imm_pkg::PROD_W'(prod_s2);

	// tags follow the ram read and the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
		end
	end

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(a_data) * $signed(b_data);
		end
		if (step) begin
			acc_q <= sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && tag_s2.last_k) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && tag_s2.last_k) begin
			row_index     <= tag_s2.row;
			col_index     <= tag_s2.col;
			product_value <= sum;
			last_result   <= tag_s2.last;
		end
	end

endmodule

/* hdl/integer_matrix_multiply_unit.sv */
// Load: one element per cycle, ready stays high until the last B element.
// Compute: one shared 16x16 multiply-accumulate runs rows*cols*inner steps, one a
// cycle while no result stalls at the output, through a 3-stage ram/multiply/
// accumulate path; ready is low meanwhile. Ready returns with the last result.
// Reset sets the dimension registers to 8 and clears the counters; stores keep data.
module integer_matrix_multiply_unit #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [imm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [imm_pkg::REG_W-1:0]         cfg_data,
	input  logic                              element_valid,
	output logic                              element_ready,
	input  logic signed [imm_pkg::ELEM_W-1:0] element,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [imm_pkg::DIM_W-1:0]         row_index,
	output logic [imm_pkg::DIM_W-1:0]         col_index,
	output logic signed [imm_pkg::PROD_W-1:0] product_value,
	output logic                              last_result
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	imm_pkg::mac_tag_t issue;
	logic adv, calc_done, a_wr_en, b_wr_en;
	logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
	logic [imm_pkg::ELEM_W-1:0] a_data, b_data;

	imm_ctrl #(
		.MAX_DIM(MAX_DIM),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.element_valid(element_valid),
		.element_ready(element_ready),
		.adv(adv),
		.calc_done(calc_done),
		.a_wr_en(a_wr_en),
		.b_wr_en(b_wr_en),
		.wr_addr(wr_addr),
		.a_rd_addr(a_rd_addr),
		.b_rd_addr(b_rd_addr),
		.issue(issue)
	);

	// matrix A store
	imm_ram #(
		.WIDTH(imm_pkg::ELEM_W),
		.DEPTH(DEPTH)
	) u_ram_a (
		.clk(clk),
		.wr_en(a_wr_en),
		.wr_addr(wr_addr),
		.wr_data(element),
		.rd_en(adv),
		.rd_addr(a_rd_addr),
		.rd_data(a_data)
	);

	// matrix B store
	imm_ram #(
		.WIDTH(imm_pkg::ELEM_W),
		.DEPTH(DEPTH)
	) u_ram_b (
		.clk(clk),
		.wr_en(b_wr_en),
		.wr_addr(wr_addr),
		.wr_data(element),
		.rd_en(adv),
		.rd_addr(b_rd_addr),
		.rd_data(b_data)
	);

	imm_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.issue(issue),
		.a_data(a_data),
		.b_data(b_data),
		.adv(adv),
		.calc_done(calc_done),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.row_index(row_index),
		.col_index(col_index),
		.product_value(product_value),
		.last_result(last_result)
	);

endmodule

/* hdl/imm_checker.sv */
`include "integer_matrix_multiply_unit_defines.svh"

module imm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              element_valid,
	input logic                              element_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic signed [imm_pkg::PROD_W-1:0] product_value,
	input logic                              last_result
);

	// a stalled result holds its value
	`IMM_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(product_value), "result changed while stalled")

	// no new element is taken while a matrix is still being delivered
	`IMM_ASSERT_IMPL(a_busy_while_emitting, clk, arst_n, result_valid && !last_result, !element_ready, "element ready while product pending")

	// loading reopens only together with the final result
	`IMM_ASSERT_IMPL(a_ready_with_last, clk, arst_n, $rose(element_ready), result_valid && last_result, "ready rose without last result")

	// taking an element never brings a result in the next cycle
	`IMM_ASSERT_NEXT(a_result_not_early, clk, arst_n, element_valid && element_ready && !result_valid, !result_valid, "result while loading")

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.element_valid(element_valid),
	.element_ready(element_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.product_value(product_value),
	.last_result(last_result)
);
